>>> rtl/core/bmoq_pkg.sv
// Shared types and constants of the block minimum-offset quantizer.
// Holds the controller/datapath command and status structs and the field widths.
// No dependencies.
package bmoq_pkg;

  // Default sizing, handed down through the top-level parameters
  localparam int unsigned MaxSetsDef    = 32;
  localparam int unsigned SampleBitsDef = 20;

  // Fixed field widths
  localparam int unsigned CodeW     = 16;  // width of one coded axis offset
  localparam int unsigned DropW     = 5;   // width of one axis right shift
  localparam int unsigned CfgW      = 5;   // width of the code_bits register
  localparam int unsigned CodeLimit = 16;  // largest legal code_bits value
  localparam int unsigned CodeBitsRst = 16;

  // Configuration register map (word index)
  localparam logic CfgIdxCodeBits = 1'b0;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the word on the input side
    logic calc_range;  // register max minus min of each axis
    logic calc_drop;   // register the right shift of each axis, rewind readout
    logic emit;        // stream stored sets out
  } bmoq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic load_last;   // the word being loaded closes the block
    logic emit_done;   // every stored set has been read and handed on
  } bmoq_sts_t;

endpackage

>>> rtl/core/block_min_offset_quantizer_unit.sv
// Top level of the block minimum-offset quantizer: stream ports, APB register.
// Instantiates bmoq_ctrl and bmoq_datapath; depends on bmoq_pkg.
//
// The unit loads a block of three-axis signed sample sets, one word per cycle,
// into an internal store of MAX_SETS entries while tracking each axis minimum
// and maximum. The word with tlast set, or the word that fills the store, closes
// the block; the input then stays stalled (s_tready low) for the whole readout.
// After the closing word, the range step registers max minus min per axis and
// the shift step turns the bit length of that range into a right shift of
// max(0, length minus code_bits). The stored sets are then read from the store
// in arrival order, one per cycle while the master side keeps tready high,
// each result leaving through the store's registered read port and the output
// register; the store's single read port sets the one-result-per-cycle
// readout. Every result word carries the three offsets from the axis minimums,
// shifted, plus the minimums and the shifts; tlast marks the result of the
// block's last set. code_bits sits at byte address 0 of the APB port, is clamped
// to 1..16 on write and resets to 16; write it only while the unit is idle.
module block_min_offset_quantizer_unit
  import bmoq_pkg::*;
#(
  parameter int unsigned MAX_SETS    = MaxSetsDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef,
  localparam int unsigned InW  = 3 * SAMPLE_BITS,
  localparam int unsigned InTW = ((InW + 7) / 8) * 8,
  localparam int unsigned OutW = 3 * CodeW + 3 * SAMPLE_BITS + 3 * DropW,
  localparam int unsigned OutTW = ((OutW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input stream
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [InTW-1:0]  s_tdata,   // x_sample, y_sample, z_sample, zero fill
  input  logic             s_tlast,   // block_end
  // Result stream
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OutTW-1:0] m_tdata,   // x_code, y_code, z_code, x_floor, y_floor,
                                      // z_floor, x_drop, y_drop, z_drop, zero fill
  output logic             m_tlast,   // final_code
  // APB register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned SB = SAMPLE_BITS;

  logic [CfgW-1:0] code_bits_q, code_bits_d;
  logic [CfgW-1:0] wr_val;
  logic            cfg_wr;

  bmoq_cmd_t cmd;
  bmoq_sts_t sts;

  logic [CodeW-1:0]     x_code, y_code, z_code;
  logic signed [SB-1:0] x_floor, y_floor, z_floor;
  logic [DropW-1:0]     x_drop, y_drop, z_drop;

  // Configuration register: take the low bits, clamp to 1..16
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CfgIdxCodeBits);
  assign wr_val = pwdata[CfgW-1:0];

  always_comb begin
    code_bits_d = code_bits_q;
    if (cfg_wr) begin
      if (wr_val == '0) begin
        code_bits_d = CfgW'(1);
      end else if (wr_val > CfgW'(CodeLimit)) begin
        code_bits_d = CfgW'(CodeLimit);
      end else begin
        code_bits_d = wr_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= CfgW'(CodeBitsRst);
    end else begin
      code_bits_q <= code_bits_d;
    end
  end

  assign prdata = (paddr[2] == CfgIdxCodeBits) ? 32'(code_bits_q) : '0;

  bmoq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bmoq_datapath #(
    .MAX_SETS    (MAX_SETS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .code_bits_i  (code_bits_q),
    .x_sample_i   (s_tdata[SB-1:0]),
    .y_sample_i   (s_tdata[2*SB-1:SB]),
    .z_sample_i   (s_tdata[3*SB-1:2*SB]),
    .block_end_i  (s_tlast),
    .out_ready_i  (m_tready),
    .out_valid_o  (m_tvalid),
    .x_code_o     (x_code),
    .y_code_o     (y_code),
    .z_code_o     (z_code),
    .x_floor_o    (x_floor),
    .y_floor_o    (y_floor),
    .z_floor_o    (z_floor),
    .x_drop_o     (x_drop),
    .y_drop_o     (y_drop),
    .z_drop_o     (z_drop),
    .final_code_o (m_tlast)
  );

  // Pack the result word, first field in the low bits
  assign m_tdata = OutTW'({z_drop, y_drop, x_drop, z_floor, y_floor, x_floor,
                           z_code, y_code, x_code});

  // Only one phase of the sequence is active at a time
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("controller raised more than one command");

  // A closing word stalls the input for the readout
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still open after the closing word");

  // The register never leaves its legal range
  a_code_bits_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_bits_q >= CfgW'(1)) && (code_bits_q <= CfgW'(CodeLimit)))
    else $error("code_bits outside 1..16");

  // A shift never exceeds what the sample width allows
  a_drop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (x_drop < DropW'(SB)) && (y_drop < DropW'(SB)) && (z_drop < DropW'(SB)))
    else $error("axis shift out of range");

endmodule

>>> rtl/core/bmoq_ctrl.sv
// Sequencer of the block minimum-offset quantizer: load, range, shift, emit.
// Depends on bmoq_pkg.
module bmoq_ctrl
  import bmoq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  bmoq_sts_t sts_i,
  output bmoq_cmd_t cmd_o
);

  localparam logic [1:0] StLoad  = 2'd0;
  localparam logic [1:0] StRange = 2'd1;
  localparam logic [1:0] StDrop  = 2'd2;
  localparam logic [1:0] StEmit  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StLoad: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && sts_i.load_last) state_d = StRange;
      end
      StRange: begin
        cmd_o.calc_range = 1'b1;
        state_d          = StDrop;
      end
      StDrop: begin
        cmd_o.calc_drop = 1'b1;
        state_d         = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_done) state_d = StLoad;
      end
      default: state_d = StLoad;
    endcase
  end

  assign in_ready_o = (state_q == StLoad);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/bmoq_datapath.sv
// Datapath of the block minimum-offset quantizer: sample store, min/max
// tracking, range and shift registers, readout pipeline and output register.
// Depends on bmoq_pkg.
module bmoq_datapath
  import bmoq_pkg::*;
#(
  parameter int unsigned MAX_SETS    = MaxSetsDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmoq_cmd_t                     cmd_i,
  output bmoq_sts_t                     sts_o,
  input  logic [CfgW-1:0]               code_bits_i,
  input  logic signed [SAMPLE_BITS-1:0] x_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] y_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] z_sample_i,
  input  logic                          block_end_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [CodeW-1:0]              x_code_o,
  output logic [CodeW-1:0]              y_code_o,
  output logic [CodeW-1:0]              z_code_o,
  output logic signed [SAMPLE_BITS-1:0] x_floor_o,
  output logic signed [SAMPLE_BITS-1:0] y_floor_o,
  output logic signed [SAMPLE_BITS-1:0] z_floor_o,
  output logic [DropW-1:0]              x_drop_o,
  output logic [DropW-1:0]              y_drop_o,
  output logic [DropW-1:0]              z_drop_o,
  output logic                          final_code_o
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned AW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned FCW = $clog2(MAX_SETS + 1);
  localparam int unsigned BLW = $clog2(SB + 1);
  localparam int unsigned CMW = (BLW > CfgW) ? BLW : CfgW;
  localparam int unsigned DW  = (SB > CodeW) ? SB : CodeW;

  logic [3*SB-1:0] mem [MAX_SETS];

  logic [FCW-1:0]       fill_q;
  logic [FCW-1:0]       emit_cnt_q;
  logic signed [SB-1:0] min_q [3];
  logic signed [SB-1:0] max_q [3];
  logic [SB-1:0]        range_q [3];
  logic [DropW-1:0]     drop_q [3];

  logic            rd_valid_q;
  logic            rd_last_q;
  logic [3*SB-1:0] rd_data_q;

  logic                 out_valid_q;
  logic                 out_last_q;
  logic [CodeW-1:0]     out_code_q [3];
  logic signed [SB-1:0] out_floor_q [3];
  logic [DropW-1:0]     out_drop_q [3];

  logic signed [SB-1:0] smp [3];
  logic [FCW-1:0]       fill_inc;
  logic                 out_free;
  logic                 issue;
  logic                 advance;
  logic [BLW-1:0]       blen [3];
  logic [CMW-1:0]       blen_e [3];
  logic [CMW-1:0]       cb_e;
  logic [CodeW-1:0]     code [3];
  logic [SB-1:0]        diff [3];
  logic [DW-1:0]        diff_e [3];
  logic [DW-1:0]        shifted [3];

  assign smp[0]   = x_sample_i;
  assign smp[1]   = y_sample_i;
  assign smp[2]   = z_sample_i;
  assign fill_inc = fill_q + FCW'(1);

  // A set that fills the store closes the block
  assign sts_o.load_last = block_end_i || (fill_inc == FCW'(MAX_SETS));
  assign sts_o.emit_done = (emit_cnt_q == fill_q) && !rd_valid_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = rd_valid_q && out_free;
  assign issue    = cmd_i.emit && (emit_cnt_q != fill_q) && (!rd_valid_q || out_free);

  // Bit length of each range
  always_comb begin
    cb_e = CMW'(code_bits_i);
    for (int a = 0; a < 3; a++) begin
      blen[a] = '0;
      for (int i = 0; i < SB; i++) begin
        if (range_q[a][i]) blen[a] = BLW'(i + 1);
      end
      blen_e[a] = CMW'(blen[a]);
    end
  end

  // Offset from the axis minimum, shifted and cut to the code width
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]    = rd_data_q[a*SB +: SB] - min_q[a];
      diff_e[a]  = DW'(diff[a]);
      shifted[a] = diff_e[a] >> drop_q[a];
      code[a]    = shifted[a][CodeW-1:0];
    end
  end

  // Sample store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[fill_q[AW-1:0]] <= {z_sample_i, y_sample_i, x_sample_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem[emit_cnt_q[AW-1:0]];
      rd_last_q <= (emit_cnt_q + FCW'(1) == fill_q);
    end
  end

  // Per-block arithmetic registers
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd_i.load) begin
        if (fill_q == '0) begin
          min_q[a] <= smp[a];
          max_q[a] <= smp[a];
        end else begin
          if (smp[a] < min_q[a]) min_q[a] <= smp[a];
          if (smp[a] > max_q[a]) max_q[a] <= smp[a];
        end
      end
      if (cmd_i.calc_range) range_q[a] <= SB'(max_q[a] - min_q[a]);
      if (cmd_i.calc_drop) begin
        drop_q[a] <= (blen_e[a] > cb_e) ? DropW'(blen_e[a] - cb_e) : '0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_last_q <= rd_last_q;
      for (int a = 0; a < 3; a++) begin
        out_code_q[a]  <= code[a];
        out_floor_q[a] <= min_q[a];
        out_drop_q[a]  <= drop_q[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      emit_cnt_q  <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        fill_q <= fill_inc;
      end else if (cmd_i.emit && sts_o.emit_done) begin
        fill_q <= '0;
      end
      if (cmd_i.calc_drop) begin
        emit_cnt_q <= '0;
      end else if (issue) begin
        emit_cnt_q <= emit_cnt_q + FCW'(1);
      end
      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (out_free) begin
        rd_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign final_code_o = out_last_q;
  assign x_code_o     = out_code_q[0];
  assign y_code_o     = out_code_q[1];
  assign z_code_o     = out_code_q[2];
  assign x_floor_o    = out_floor_q[0];
  assign y_floor_o    = out_floor_q[1];
  assign z_floor_o    = out_floor_q[2];
  assign x_drop_o     = out_drop_q[0];
  assign y_drop_o     = out_drop_q[1];
  assign z_drop_o     = out_drop_q[2];

endmodule
